/* hdl/calendar_date_counter_assert.svh */
// Assertion macros shared by the calendar date counter modules.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef CALENDAR_DATE_COUNTER_ASSERT_SVH
`define CALENDAR_DATE_COUNTER_ASSERT_SVH

// Same-cycle implication.
`define CAL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define CAL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/cal_pkg.sv */
// Shared types, constants and calendar functions for the date counter.
// No dependencies; imported by cal_ctrl, cal_dp and calendar_date_counter.
`timescale 1ns / 1ps

package cal_pkg;

  localparam int COUNT_WIDTH = 16;
  localparam int DCNT_W      = 16;   // width of the day_count field
  localparam int CNT_W       = (COUNT_WIDTH < DCNT_W) ? COUNT_WIDTH : DCNT_W;

  localparam int YEAR_W  = 12;
  localparam int MONTH_W = 4;
  localparam int DAY_W   = 5;
  localparam int OP_W    = 3;

  localparam logic [YEAR_W-1:0]  YEAR_MIN  = 12'd1900;
  localparam logic [YEAR_W-1:0]  YEAR_MAX  = 12'd2100;
  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
  localparam logic [DAY_W-1:0]   DAY_FIRST = 5'd1;
  localparam logic [DAY_W-1:0]   DAY_LEAP  = 5'd29;

  // divisible by 25 test: y * inv(25) mod 2^12 <= floor(4095 / 25)
  localparam logic [YEAR_W-1:0] INV25     = 12'd3113;
  localparam logic [YEAR_W-1:0] DIV25_MAX = 12'd163;

  localparam logic [DAY_W-1:0] MONTH_LEN [16] = '{
    5'd31, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31,
    5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31, 5'd31, 5'd31
  };

  typedef enum logic [OP_W-1:0] {
    OP_SET  = 3'd0,
    OP_NEXT = 3'd1,
    OP_PREV = 3'd2,
    OP_ADD  = 3'd3,
    OP_SUB  = 3'd4
  } cal_op_t;

  typedef struct packed {
    logic set;
    logic inc;
    logic dec;
    logic cnt_load;
    logic cnt_dec;
    logic out_load;
  } cal_cmd_t;

  typedef struct packed {
    logic in_cnt_zero;
    logic cnt_last;
    logic cnt_zero;
  } cal_stat_t;

  // Gregorian rule: leap if div by 4 and (not div by 100 or div by 400).
  // Given div by 4: div by 100 <=> div by 25, div by 400 <=> div by 16.
  function automatic logic is_leap(input logic [YEAR_W-1:0] y);
    logic [2*YEAR_W-1:0] prod;
    logic                div25;
    prod  = y * INV25;
    div25 = (prod[YEAR_W-1:0] <= DIV25_MAX);
    return (y[1:0] == 2'b00) && (!div25 || (y[3:0] == 4'b0000));
  endfunction

  function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] m,
                                               input logic leap);
    if ((m == MONTH_FEB) && leap) begin
      return DAY_LEAP;
    end
    return MONTH_LEN[m];
  endfunction

endpackage

/* hdl/cal_dp.sv */
// Datapath: date registers, day step and set logic, day counter, result register.
// Depends on cal_pkg; driven by cal_ctrl through cal_cmd_t.
`timescale 1ns / 1ps

module cal_dp import cal_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  cal_cmd_t            cmd,
  output cal_stat_t           stat,
  input  logic [MONTH_W-1:0]  in_month_in,
  input  logic [DAY_W-1:0]    in_day_in,
  input  logic [YEAR_W-1:0]   in_year_in,
  input  logic [DCNT_W-1:0]   in_day_count,
  output logic [MONTH_W-1:0]  out_month_out,
  output logic [DAY_W-1:0]    out_day_out,
  output logic [YEAR_W-1:0]   out_year_out
);

  logic [DAY_W-1:0]   day_r,   day_nxt;
  logic [MONTH_W-1:0] month_r, month_nxt;
  logic [YEAR_W-1:0]  year_r,  year_nxt;
  logic [CNT_W-1:0]   cnt_r,   cnt_nxt;
  logic [MONTH_W-1:0] out_month_r;
  logic [DAY_W-1:0]   out_day_r;
  logic [YEAR_W-1:0]  out_year_r;

  logic [MONTH_W-1:0] set_month;
  logic [YEAR_W-1:0]  set_year;
  logic [YEAR_W-1:0]  leap_year;
  logic               leap;
  logic [DAY_W-1:0]   dim_cur;
  logic [DAY_W-1:0]   dim_set;
  logic [MONTH_W-1:0] prev_month;

  assign set_month = ((in_month_in >= MONTH_JAN) && (in_month_in <= MONTH_DEC)) ?
                     in_month_in : MONTH_JAN;
  assign set_year  = ((in_year_in >= YEAR_MIN) && (in_year_in <= YEAR_MAX)) ?
                     in_year_in : YEAR_MIN;

  // single leap unit, shared by set and step
  assign leap_year  = cmd.set ? set_year : year_r;
  assign leap       = is_leap(leap_year);
  assign dim_cur    = days_in(month_r, leap);
  assign dim_set    = days_in(set_month, leap);
  assign prev_month = (month_r <= MONTH_JAN) ? MONTH_DEC : month_r - MONTH_JAN;

  always_comb begin
    day_nxt   = day_r;
    month_nxt = month_r;
    year_nxt  = year_r;
    if (cmd.set) begin
      month_nxt = set_month;
      year_nxt  = set_year;
      day_nxt   = ((in_day_in >= DAY_FIRST) && (in_day_in <= dim_set)) ?
                  in_day_in : DAY_FIRST;
    end else if (cmd.inc) begin
      if (day_r >= dim_cur) begin
        day_nxt = DAY_FIRST;
        if (month_r >= MONTH_DEC) begin
          month_nxt = MONTH_JAN;
          year_nxt  = year_r + 12'd1;
        end else begin
          month_nxt = month_r + MONTH_JAN;
        end
      end else begin
        day_nxt = day_r + DAY_FIRST;
      end
    end else if (cmd.dec) begin
      if (day_r <= DAY_FIRST) begin
        month_nxt = prev_month;
        // year only changes on the way to December, where leap is irrelevant
        day_nxt   = days_in(prev_month, leap);
        if (month_r <= MONTH_JAN) begin
          year_nxt = year_r - 12'd1;
        end
      end else begin
        day_nxt = day_r - DAY_FIRST;
      end
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.cnt_load) begin
      cnt_nxt = in_day_count[CNT_W-1:0];
    end else if (cmd.cnt_dec) begin
      cnt_nxt = cnt_r - {{(CNT_W-1){1'b0}}, 1'b1};
    end
  end

  assign stat.in_cnt_zero = (in_day_count[CNT_W-1:0] == '0);
  assign stat.cnt_last    = (cnt_r == {{(CNT_W-1){1'b0}}, 1'b1});
  assign stat.cnt_zero    = (cnt_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      day_r   <= DAY_FIRST;
      month_r <= MONTH_JAN;
      year_r  <= YEAR_MIN;
    end else begin
      day_r   <= day_nxt;
      month_r <= month_nxt;
      year_r  <= year_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r <= cnt_nxt;
    if (cmd.out_load) begin
      out_month_r <= month_nxt;
      out_day_r   <= day_nxt;
      out_year_r  <= year_nxt;
    end
  end

  assign out_month_out = out_month_r;
  assign out_day_out   = out_day_r;
  assign out_year_out  = out_year_r;

`include "calendar_date_counter_assert.svh"

  `CAL_ASSERT_NOW(a_month_range, 1'b1, (month_r >= MONTH_JAN) && (month_r <= MONTH_DEC), "month out of range")
  `CAL_ASSERT_NOW(a_day_range, !cmd.set, (day_r >= DAY_FIRST) && (day_r <= dim_cur), "day past month end")

endmodule

/* hdl/cal_ctrl.sv */
// Controller FSM: command decode, day-count sequencing, result handshake.
// Depends on cal_pkg; drives cal_dp through cal_cmd_t.
`timescale 1ns / 1ps

module cal_ctrl import cal_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [OP_W-1:0]   in_opcode,
  output logic              out_valid,
  input  logic              out_stall,
  output cal_cmd_t          cmd,
  input  cal_stat_t         stat
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_WAIT
  } state_t;

  state_t  state_r, state_nxt;
  logic    dir_add_r, dir_add_nxt;
  logic    out_valid_r, out_valid_nxt;
  logic    accept;
  logic    out_free;
  logic    done;
  cal_op_t op;

  assign op       = cal_op_t'(in_opcode);
  assign accept   = in_valid && (state_r == S_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    cmd         = '0;
    state_nxt   = state_r;
    dir_add_nxt = dir_add_r;
    done        = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (op)
            OP_SET:  begin cmd.set = 1'b1; done = 1'b1; end
            OP_NEXT: begin cmd.inc = 1'b1; done = 1'b1; end
            OP_PREV: begin cmd.dec = 1'b1; done = 1'b1; end
            OP_ADD, OP_SUB: begin
              if (stat.in_cnt_zero) begin
                done = 1'b1;
              end else begin
                cmd.cnt_load = 1'b1;
                dir_add_nxt  = (op == OP_ADD);
                state_nxt    = S_RUN;
              end
            end
            default: done = 1'b1;
          endcase
        end
      end
      S_RUN: begin
        cmd.inc     = dir_add_r;
        cmd.dec     = !dir_add_r;
        cmd.cnt_dec = 1'b1;
        done        = stat.cnt_last;
      end
      S_WAIT: begin
        done = 1'b1;
      end
      default: state_nxt = S_IDLE;
    endcase

    if (done) begin
      if (out_free) begin
        cmd.out_load = 1'b1;
        state_nxt    = S_IDLE;
      end else begin
        state_nxt = S_WAIT;
      end
    end

    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      dir_add_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      dir_add_r   <= dir_add_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

`include "calendar_date_counter_assert.svh"

  `CAL_ASSERT_NOW(a_no_overwrite, out_valid_r && out_stall, !cmd.out_load, "result overwritten while stalled")
  `CAL_ASSERT_NOW(a_run_count, state_r == S_RUN, !stat.cnt_zero, "stepping with empty day count")
  `CAL_ASSERT_NEXT(a_set_done, accept && (op == OP_SET), out_valid_r || (state_r == S_WAIT), "set transfer produced no result")

endmodule

/* hdl/calendar_date_counter.sv */
// Top level of the Gregorian calendar date counter.
// Depends on cal_pkg, cal_ctrl and cal_dp.
`timescale 1ns / 1ps

// Holds one Gregorian date and applies one command per input transfer:
// set (validated: bad month -> 1, year outside 1900..2100 -> 1900, bad day
// -> 1, Feb 29 only in leap years), next day, previous day, add N days or
// subtract N days, with N taken from the low COUNT_WIDTH bits of
// in_day_count. Every command yields exactly one result transfer carrying
// the date after the command; unused opcodes return the date unchanged.
// The year wraps modulo 4096 and year 0 counts as leap. Reset gives
// 1 January 1900. Timing: set, next, previous, unused opcodes and add or
// subtract of zero days finish in the cycle the input transfer is taken
// if the output register is free; add or subtract of N > 0 days steps the
// date in the single day-step unit, one day per clock. The input is stalled
// while a count is running or while a finished result cannot yet enter the
// output register; a result waiting in the output register does not by
// itself block the next input transfer.

module calendar_date_counter import cal_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  // input channel
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [OP_W-1:0]     in_opcode,
  input  logic [MONTH_W-1:0]  in_month_in,
  input  logic [DAY_W-1:0]    in_day_in,
  input  logic [YEAR_W-1:0]   in_year_in,
  input  logic [DCNT_W-1:0]   in_day_count,
  // result channel
  output logic                out_valid,
  input  logic                out_stall,
  output logic [MONTH_W-1:0]  out_month_out,
  output logic [DAY_W-1:0]    out_day_out,
  output logic [YEAR_W-1:0]   out_year_out
);

  cal_cmd_t  cmd;
  cal_stat_t stat;

  // sequencing and handshakes
  cal_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_opcode (in_opcode),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  // date state, calendar arithmetic and result register
  cal_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_month_in   (in_month_in),
    .in_day_in     (in_day_in),
    .in_year_in    (in_year_in),
    .in_day_count  (in_day_count),
    .out_month_out (out_month_out),
    .out_day_out   (out_day_out),
    .out_year_out  (out_year_out)
  );

endmodule
